/* rtl/max_heap_priority_queue_top_defines.svh */
// Assertion macros for the max-heap priority queue checker.
// Used by mhpq_chk; needs clk and rst_n in the including scope.
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH

// implication in the same cycle
`define MHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication in the next cycle
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mhpq_pkg.sv */
// Shared types, sizes and codes of the max-heap priority queue.
// No dependencies.
package mhpq_pkg;

    localparam int CAPACITY    = 128;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W       = ADDR_W + 2;
    localparam int PRIO_W      = 16;
    localparam int LANE_W      = 7;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 8;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [LANE_W-1:0] lane;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        slot_t             wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [PRIO_W-1:0]      top_prio;
        logic [LANE_W-1:0]      top_lane;
        logic [COUNT_OUT_W-1:0] count;
    } res_t;

endpackage

/* rtl/mhpq_ram.sv */
// Simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module mhpq_ram #(
    parameter int DATA_W = 23,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/mhpq_seq.sv */
// Heap sequencer: command decode, sift-up and sift-down over one shared comparator.
// Depends on mhpq_pkg; drives the heap RAM through a mem_req_t.
module mhpq_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mhpq_pkg::CMD_W-1:0]     cmd,
    input  logic [mhpq_pkg::PRIO_W-1:0]    prio_in,
    input  logic [mhpq_pkg::LANE_W-1:0]    lane_in,
    output mhpq_pkg::mem_req_t             mem_req,
    input  mhpq_pkg::slot_t                mem_rdata,
    output logic                           res_valid,
    input  logic                           res_ready,
    output mhpq_pkg::res_t                 res
);

    import mhpq_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UP_RD    = 4'd1;
    localparam logic [3:0] S_UP_CMP   = 4'd2;
    localparam logic [3:0] S_POP_RD0  = 4'd3;
    localparam logic [3:0] S_POP_RDL  = 4'd4;
    localparam logic [3:0] S_POP_LAST = 4'd5;
    localparam logic [3:0] S_DN_RL    = 4'd6;
    localparam logic [3:0] S_DN_RR    = 4'd7;
    localparam logic [3:0] S_DN_CMP   = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    slot_t               ent_reg, ent_next;
    slot_t               best_reg, best_next;
    logic                best_left_reg, best_left_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    slot_t               top_reg, top_next;

    logic [IDX_W-1:0]    left_idx;
    logic [IDX_W-1:0]    right_idx;
    logic [IDX_W-1:0]    count_idx;
    logic [ADDR_W-1:0]   parent_pos;
    slot_t               cmp_hi;
    slot_t               cmp_lo;
    logic                cmp_gt;

    assign left_idx   = (IDX_W'(pos_reg) << 1) + IDX_W'(1);
    assign right_idx  = (IDX_W'(pos_reg) << 1) + IDX_W'(2);
    assign count_idx  = IDX_W'(count_reg);
    assign parent_pos = ADDR_W'((pos_reg - ADDR_W'(1)) >> 1);

    always_comb
    begin
        case (state_reg)
            S_UP_CMP:
            begin
                cmp_hi = ent_reg;
                cmp_lo = mem_rdata;
            end
            S_DN_RR:
            begin
                cmp_hi = mem_rdata;
                cmp_lo = ent_reg;
            end
            default:
            begin
                cmp_hi = mem_rdata;
                cmp_lo = best_reg;
            end
        endcase
    end

    assign cmp_gt = cmp_hi.prio > cmp_lo.prio;

    assign in_stall      = (state_reg != S_IDLE);
    assign res_valid     = (state_reg == S_DONE);
    assign res.status    = status_reg;
    assign res.top_prio  = top_reg.prio;
    assign res.top_lane  = top_reg.lane;
    assign res.count     = COUNT_OUT_W'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        ent_next       = ent_reg;
        best_next      = best_reg;
        best_left_next = best_left_reg;
        status_next    = status_reg;
        top_next       = top_reg;
        mem_req.we     = 1'b0;
        mem_req.waddr  = pos_reg;
        mem_req.wdata  = ent_reg;
        mem_req.raddr  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    status_next = STATUS_OK;
                    top_next    = '0;
                    state_next  = S_DONE;
                    case (cmd)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_INSERT:
                        begin
                            if (count_reg >= COUNT_W'(CAPACITY))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ent_next.prio = prio_in;
                                ent_next.lane = lane_in;
                                pos_next      = ADDR_W'(count_reg);
                                count_next    = count_reg + COUNT_W'(1);
                                state_next    = S_UP_RD;
                            end
                        end
                        CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                state_next = S_POP_RD0;
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_req.we = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_req.raddr = parent_pos;
                    state_next    = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                mem_req.we = 1'b1;
                if (cmp_gt)
                begin
                    mem_req.wdata = mem_rdata;
                    pos_next      = parent_pos;
                    state_next    = S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POP_RD0:
            begin
                mem_req.raddr = '0;
                state_next    = S_POP_RDL;
            end
            S_POP_RDL:
            begin
                mem_req.raddr = ADDR_W'(count_reg - COUNT_W'(1));
                top_next      = mem_rdata;
                count_next    = count_reg - COUNT_W'(1);
                pos_next      = '0;
                state_next    = S_POP_LAST;
            end
            S_POP_LAST:
            begin
                ent_next   = mem_rdata;
                state_next = S_DN_RL;
            end
            S_DN_RL:
            begin
                if (left_idx >= count_idx)
                begin
                    mem_req.we = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_req.raddr = ADDR_W'(left_idx);
                    state_next    = S_DN_RR;
                end
            end
            S_DN_RR:
            begin
                mem_req.raddr  = ADDR_W'(right_idx);
                best_next      = cmp_gt ? mem_rdata : ent_reg;
                best_left_next = cmp_gt;
                state_next     = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                mem_req.we = 1'b1;
                if ((right_idx < count_idx) && cmp_gt)
                begin
                    mem_req.wdata = mem_rdata;
                    pos_next      = ADDR_W'(right_idx);
                    state_next    = S_DN_RL;
                end
                else if (best_left_reg)
                begin
                    mem_req.wdata = best_reg;
                    pos_next      = ADDR_W'(left_idx);
                    state_next    = S_DN_RL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        ent_reg       <= ent_next;
        best_reg      <= best_next;
        best_left_reg <= best_left_next;
        status_reg    <= status_next;
        top_reg       <= top_next;
    end

endmodule

/* rtl/max_heap_priority_queue_top.sv */
// Top level of the max-heap priority queue: sequencer, heap RAM, output register.
// Depends on mhpq_pkg, mhpq_seq and mhpq_ram.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   in      | sink      | in_valid/in_stall  | cmd, prio_in, lane_in
//   out     | source    | out_valid/out_stall| status, top_prio, top_lane, count
//
// Clear, error and unused commands go from idle straight to the done state.
// Insert climbs one level per pass through S_UP_RD and S_UP_CMP. Pop reads the root
// and last entry, then descends one level per pass through S_DN_RL, S_DN_RR, S_DN_CMP.
// Reset empties the heap at once; the RAM holds no reset value and needs no sweep.
// A full output register holding under out_stall does not block the next transfer
// in; the sequencer waits only when a new result finds that register full and stalled.
module max_heap_priority_queue_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [mhpq_pkg::CMD_W-1:0]      cmd,
    input  logic [mhpq_pkg::PRIO_W-1:0]     prio_in,
    input  logic [mhpq_pkg::LANE_W-1:0]     lane_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mhpq_pkg::STATUS_W-1:0]   status,
    output logic [mhpq_pkg::PRIO_W-1:0]     top_prio,
    output logic [mhpq_pkg::LANE_W-1:0]     top_lane,
    output logic [mhpq_pkg::COUNT_OUT_W-1:0] count
);

    import mhpq_pkg::*;

    mem_req_t mem_req;
    slot_t    mem_rdata;
    logic     res_valid;
    logic     res_ready;
    res_t     res;
    logic     out_valid_reg;
    res_t     out_reg;

    mhpq_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .prio_in   (prio_in),
        .lane_in   (lane_in),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    mhpq_ram #(
        .DATA_W (SLOT_W),
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_reg.status;
    assign top_prio  = out_reg.top_prio;
    assign top_lane  = out_reg.top_lane;
    assign count     = out_reg.count;

endmodule

/* rtl/mhpq_chk.sv */
// Port-level checker for the max-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and max_heap_priority_queue_top_defines.svh.
`include "max_heap_priority_queue_top_defines.svh"

module mhpq_chk (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic [mhpq_pkg::CMD_W-1:0]       cmd,
    input logic [mhpq_pkg::PRIO_W-1:0]      prio_in,
    input logic [mhpq_pkg::LANE_W-1:0]      lane_in,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [mhpq_pkg::STATUS_W-1:0]    status,
    input logic [mhpq_pkg::PRIO_W-1:0]      top_prio,
    input logic [mhpq_pkg::LANE_W-1:0]      top_lane,
    input logic [mhpq_pkg::COUNT_OUT_W-1:0] count
);

    import mhpq_pkg::*;

    `MHPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(status) && $stable(count) && $stable(top_prio),
        "stalled result changed")

    `MHPQ_ASSERT_NOW(a_count_cap, out_valid,
        count <= COUNT_OUT_W'(CAPACITY),
        "count above capacity")

    `MHPQ_ASSERT_NOW(a_err_top_zero, out_valid && (status != STATUS_OK),
        (top_prio == '0) && (top_lane == '0),
        "error result carries a popped entry")

    `MHPQ_ASSERT_NOW(a_empty_count, out_valid && (status == STATUS_EMPTY),
        count == '0,
        "empty status with entries held")

    `MHPQ_ASSERT_NOW(a_full_count, out_valid && (status == STATUS_FULL),
        count == COUNT_OUT_W'(CAPACITY),
        "full status below capacity")

endmodule

bind max_heap_priority_queue_top mhpq_chk u_chk (.*);

/* sim/testbench.sv */
// Self-checking testbench for max_heap_priority_queue_top: clear, insert, pop and
// unused commands are checked against a heap mirror kept inside the testbench.
// Depends on mhpq_pkg and the RTL of max_heap_priority_queue_top.
module testbench;
    import mhpq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int ITEMS       = 1750;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [PRIO_W-1:0] prio;
        logic [LANE_W-1:0] lane;
    } heap_cmd_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [CMD_W-1:0]       cmd = CMD_CLEAR;
    logic [PRIO_W-1:0]      prio_in = '0;
    logic [LANE_W-1:0]      lane_in = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic [PRIO_W-1:0]      top_prio;
    logic [LANE_W-1:0]      top_lane;
    logic [COUNT_OUT_W-1:0] count;

    heap_cmd_t pending_cmds[$];
    res_t      expected_results[$];
    heap_cmd_t next_cmd;
    res_t      got_result;
    res_t      want_result;

    slot_t heap_mirror [CAPACITY];
    int    mirror_count = 0;
    int    planned_count = 0;
    int    planned_items = 0;
    int    total_cmds = 1;
    int    transfers_in = 0;
    int    idle_cycles = 0;
    int    errors = 0;

    max_heap_priority_queue_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .prio_in   (prio_in),
        .lane_in   (lane_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .top_prio  (top_prio),
        .top_lane  (top_lane),
        .count     (count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int idle_pct(bit sender);
        int phase;
        phase = transfers_in * 3 / total_cmds;
        if (phase == 0)
            return sender ? 26 : 80;
        else if (phase == 1)
            return sender ? 80 : 26;
        return 0;
    endfunction

    function automatic void exchange(int a, int b);
        slot_t tmp;
        tmp = heap_mirror[a];
        heap_mirror[a] = heap_mirror[b];
        heap_mirror[b] = tmp;
    endfunction

    function automatic res_t heap_apply(logic [CMD_W-1:0] op, logic [PRIO_W-1:0] p,
                                        logic [LANE_W-1:0] l);
        res_t r;
        int   pos;
        int   parent;
        int   left;
        int   best;
        bit   settled;
        r = '0;
        case (op)
            CMD_CLEAR:
                mirror_count = 0;
            CMD_INSERT:
                if (mirror_count >= CAPACITY)
                    r.status = STATUS_FULL;
                else
                begin
                    heap_mirror[mirror_count].prio = p;
                    heap_mirror[mirror_count].lane = l;
                    pos = mirror_count;
                    mirror_count++;
                    settled = 1'b0;
                    while (pos > 0 && !settled)
                    begin
                        parent = (pos - 1) / 2;
                        if (heap_mirror[parent].prio >= heap_mirror[pos].prio)
                            settled = 1'b1;
                        else
                        begin
                            exchange(pos, parent);
                            pos = parent;
                        end
                    end
                end
            CMD_POP:
                if (mirror_count == 0)
                    r.status = STATUS_EMPTY;
                else
                begin
                    r.top_prio = heap_mirror[0].prio;
                    r.top_lane = heap_mirror[0].lane;
                    heap_mirror[0] = heap_mirror[mirror_count - 1];
                    mirror_count--;
                    pos = 0;
                    settled = 1'b0;
                    while (!settled)
                    begin
                        best = pos;
                        left = 2 * pos + 1;
                        if (left < mirror_count && heap_mirror[left].prio > heap_mirror[best].prio)
                            best = left;
                        if (left + 1 < mirror_count &&
                            heap_mirror[left + 1].prio > heap_mirror[best].prio)
                            best = left + 1;
                        if (best == pos)
                            settled = 1'b1;
                        else
                        begin
                            exchange(pos, best);
                            pos = best;
                        end
                    end
                end
            default:
                ;
        endcase
        r.count = mirror_count[COUNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic plan_cmd(logic [CMD_W-1:0] op, logic [PRIO_W-1:0] p, logic [LANE_W-1:0] l);
        heap_cmd_t c;
        c.op = op;
        c.prio = p;
        c.lane = l;
        pending_cmds.push_back(c);
        if (op == CMD_CLEAR)
            planned_count = 0;
        else if (op == CMD_INSERT && planned_count < CAPACITY)
            planned_count++;
        else if (op == CMD_POP && planned_count > 0)
            planned_count--;
        if (op != CMD_UNUSED)
            planned_items++;
    endtask

    function automatic logic [PRIO_W-1:0] pick_prio();
        case ($urandom_range(0, 5))
            0:       return PRIO_W'($urandom_range(0, 7));
            1:       return $urandom_range(0, 1) ? PRIO_W'(32'hFFFF - $urandom_range(0, 1))
                                                 : PRIO_W'($urandom_range(0, 1));
            2:       return PRIO_W'(32'h8000 - $urandom_range(0, 1));
            default: return PRIO_W'($urandom());
        endcase
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want !== got)
        begin
            $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(heap_apply(cmd, prio_in, lane_in));
                transfers_in <= transfers_in + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1))
                begin
                    next_cmd = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    cmd <= next_cmd.op;
                    prio_in <= next_cmd.prio;
                    lane_in <= next_cmd.lane;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                got_result.status = status;
                got_result.top_prio = top_prio;
                got_result.top_lane = top_lane;
                got_result.count = count;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, actual status %0d prio %0d lane %0d count %0d",
                             $time, status, top_prio, top_lane, count);
                    errors++;
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    check_field("status", int'(want_result.status), int'(got_result.status));
                    check_field("top_prio", int'(want_result.top_prio),
                                int'(got_result.top_prio));
                    check_field("top_lane", int'(want_result.top_lane),
                                int'(got_result.top_lane));
                    check_field("count", int'(want_result.count), int'(got_result.count));
                end
            end
            out_stall <= ($urandom_range(0, 99) < idle_pct(1'b0));
        end
    end

    initial
    begin
        int i;
        int n;
        int r;
        // edge cases: empty heap, unused command, extremes, ties, drain
        plan_cmd(CMD_CLEAR, 16'h0000, 7'h00);
        plan_cmd(CMD_POP, 16'hFFFF, 7'h7F);
        plan_cmd(CMD_UNUSED, 16'hFFFF, 7'h7F);
        plan_cmd(CMD_INSERT, 16'hFFFF, 7'h7F);
        plan_cmd(CMD_INSERT, 16'h0000, 7'h00);
        plan_cmd(CMD_INSERT, 16'd100, 7'd5);
        plan_cmd(CMD_INSERT, 16'd100, 7'd6);
        plan_cmd(CMD_INSERT, 16'd100, 7'd7);
        plan_cmd(CMD_INSERT, 16'hFFFF, 7'd1);
        plan_cmd(CMD_INSERT, 16'h8000, 7'h55);
        plan_cmd(CMD_INSERT, 16'h7FFF, 7'h2A);
        for (i = 0; i < 9; i++)
            plan_cmd(CMD_POP, 16'h5555, 7'h2A);
        plan_cmd(CMD_INSERT, 16'd42, 7'd9);
        plan_cmd(CMD_CLEAR, 16'hFFFF, 7'h7F);
        plan_cmd(CMD_POP, 16'h0000, 7'h00);

        while (planned_items < ITEMS)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
            begin
                n = $urandom_range(5, 40);
                repeat (n)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 2)
                        plan_cmd(CMD_CLEAR, PRIO_W'($urandom()), LANE_W'($urandom()));
                    else if (r < 4)
                        plan_cmd(CMD_UNUSED, PRIO_W'($urandom()), LANE_W'($urandom()));
                    else if (r < 62)
                        plan_cmd(CMD_INSERT, pick_prio(), LANE_W'($urandom()));
                    else
                        plan_cmd(CMD_POP, PRIO_W'($urandom()), LANE_W'($urandom()));
                end
            end
            else if (r < 6)
            begin
                n = CAPACITY - planned_count + $urandom_range(0, 3);
                repeat (n)
                    plan_cmd(CMD_INSERT, pick_prio(), LANE_W'($urandom()));
            end
            else if (r < 8)
            begin
                n = $urandom_range(1, 30);
                repeat (n)
                    plan_cmd(CMD_INSERT, pick_prio(), LANE_W'($urandom()));
            end
            else
            begin
                n = planned_count + $urandom_range(0, 2);
                repeat (n)
                    plan_cmd(CMD_POP, PRIO_W'($urandom()), LANE_W'($urandom()));
            end
        end
        total_cmds = pending_cmds.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while ((pending_cmds.size() != 0 || in_valid || expected_results.size() != 0) &&
               idle_cycles < STALL_LIMIT)
            @(posedge clk);

        if (idle_cycles >= STALL_LIMIT)
            $display("simulation failed");
        else
        begin
            repeat (TAIL_CYCLES) @(posedge clk);
            if (errors == 0 && expected_results.size() == 0)
                $display("simulation ok");
            else
                $display("simulation failed");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/mhpq_seq.sv
rtl/max_heap_priority_queue_top.sv
rtl/mhpq_chk.sv
sim/testbench.sv
